// ===== src/cdes_pkg.sv =====
// ----------------------------------------------------------------------------
// cdes_pkg
// Shared widths, constants and the month offset table for the civil date to
// epoch seconds converter.
// ----------------------------------------------------------------------------
package cdes_pkg;

  // Field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int EPOCH_W  = 32;

  // Packed input is 38 bits, padded to whole bytes
  localparam int IN_BITS   = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((EPOCH_W + 7) / 8) * 8;

  // Internal widths
  localparam int SHYEAR_W = 13;  // shifted year plus one era, 399..4495
  localparam int MOFS_W   = 9;   // day offset of month start, 0..367
  localparam int TOD_W    = 17;  // time of day in seconds, below 2^17
  localparam int BASE_W   = 22;  // days before century corrections
  localparam int Q100_W   = 6;   // shifted year / 100, 0..44

  // Arithmetic constants
  localparam logic [SHYEAR_W-1:0] YEARS_PER_ERA = 13'd400;
  localparam logic [SHYEAR_W-1:0] DAYS_PER_YEAR = 13'd365;
  // Reciprocal of 100: (y * 5243) >> 19 is exact for y below 4496
  localparam logic [SHYEAR_W-1:0] RECIP_100     = 13'd5243;
  localparam int                  RECIP_SHIFT   = 19;
  // 719468 epoch shift + 146097 for the added era + 1 for the day-of-month base
  localparam logic [EPOCH_W-1:0]  DAY_BIAS      = 32'd865566;
  localparam logic [EPOCH_W-1:0]  SECS_PER_DAY  = 32'd86400;
  localparam logic [TOD_W-1:0]    SECS_PER_HOUR = 17'd3600;
  localparam logic [TOD_W-1:0]    SECS_PER_MIN  = 17'd60;

  // Days from March 1 to the first of the month, (153 * mp + 2) / 5,
  // with January and February (and month zero) as months of the prior year.
  function automatic logic [MOFS_W-1:0] month_offset(input logic [MONTH_W-1:0] mo);
    logic [MOFS_W-1:0] ofs;
    case (mo)
      4'd0:    ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd13:   ofs = 9'd306;
      4'd14:   ofs = 9'd337;
      4'd15:   ofs = 9'd367;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// ===== src/civil_date_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// civil_date_to_epoch_seconds
// Converts a calendar timestamp to Unix epoch seconds, four-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one timestamp per transfer and returns the seconds since 1970-01-01
// 00:00:00 UTC, modulo 2^32, using the proleptic Gregorian days-from-civil
// method. A new timestamp can be taken every cycle unless the pipeline is full
// and the output stalled; each result passes through one register per
// pipeline stage (month table and time of day, year scaling, century
// correction, 86400 scaling) before it is valid on the output. Every stage
// has its own valid bit and only holds when the stage after it is full and
// stalled, so bubbles are squeezed out under backpressure. The block has no
// state beyond the pipeline and no configuration.
module civil_date_to_epoch_seconds
  import cdes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
  // [31:26] minute, [37:32] second, [39:38] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // Output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [31:0] epoch_seconds
  output logic [M_TDATA_W-1:0] m_tdata
);

  // Input field split
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;

  assign year   = s_tdata[11:0];
  assign month  = s_tdata[15:12];
  assign day    = s_tdata[20:16];
  assign hour   = s_tdata[25:21];
  assign minute = s_tdata[31:26];
  assign second = s_tdata[37:32];

  // Per-stage valid and ready
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready = ~s4_valid | m_tready;
  assign s3_ready = ~s3_valid | s4_ready;
  assign s2_ready = ~s2_valid | s3_ready;
  assign s1_ready = ~s1_valid | s2_ready;
  assign s_tready = s1_ready;

  // Stage 1: shifted year, month offset, day, time of day
  logic [SHYEAR_W-1:0] s1_year;
  logic [MOFS_W-1:0]   s1_mofs;
  logic [DAY_W-1:0]    s1_day;
  logic [TOD_W-1:0]    s1_tod;
  logic                early_month;

  assign early_month = (month <= 4'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_tvalid) begin
      // one era added keeps the year non-negative for floor division
      s1_year <= SHYEAR_W'(year) + YEARS_PER_ERA - SHYEAR_W'(early_month);
      s1_mofs <= month_offset(month);
      s1_day  <= day;
      s1_tod  <= TOD_W'(hour) * SECS_PER_HOUR + TOD_W'(minute) * SECS_PER_MIN
               + TOD_W'(second);
    end
  end

  // Stage 2: year * 365 plus leap days every four years, month offset and day, century quotient
  logic [BASE_W-1:0]     s2_base;
  logic [Q100_W-1:0]     s2_q100;
  logic [TOD_W-1:0]      s2_tod;
  logic [2*SHYEAR_W-1:0] q100_prod;

  assign q100_prod = (2*SHYEAR_W)'(s1_year) * (2*SHYEAR_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_base <= BASE_W'(s1_year) * BASE_W'(DAYS_PER_YEAR)
               + BASE_W'(s1_year[SHYEAR_W-1:2])
               + BASE_W'(s1_mofs) + BASE_W'(s1_day);
      s2_q100 <= q100_prod[RECIP_SHIFT +: Q100_W];
      s2_tod  <= s1_tod;
    end
  end

  // Stage 3: century corrections and epoch bias, day count mod 2^32
  logic [EPOCH_W-1:0] s3_days;
  logic [TOD_W-1:0]   s3_tod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_days <= EPOCH_W'(s2_base) - EPOCH_W'(s2_q100)
               + EPOCH_W'(s2_q100[Q100_W-1:2]) - DAY_BIAS;
      s3_tod  <= s2_tod;
    end
  end

  // Stage 4: scale to seconds and add time of day
  logic [EPOCH_W-1:0] s4_secs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      s4_secs <= s3_days * SECS_PER_DAY + EPOCH_W'(s3_tod);
    end
  end

  assign m_tvalid = s4_valid;
  assign m_tdata  = M_TDATA_W'(s4_secs);

endmodule

// ===== src/cdes_checker.sv =====
// ----------------------------------------------------------------------------
// cdes_checker
// Port-level assertions for the epoch seconds converter, bound to the top.
// ----------------------------------------------------------------------------
module cdes_checker
  import cdes_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

  // Sink taking data frees the whole pipeline for a new transfer
  a_ready_pass: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is drained");

  // Input only stalls when a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

endmodule

bind civil_date_to_epoch_seconds cdes_checker u_cdes_checker (.*);
